// File: hw/rtl/ctt_pkg.sv
// shared types and constants for the config text tokenizer
`default_nettype none

package ctt_pkg;

    // character codes
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_GRAPH_LO = 8'h21;
    localparam logic [7:0] CH_GRAPH_HI = 8'h7E;

    // results per input item and output queue sizing
    localparam int MAX_RESULTS = 3;
    localparam int RES_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 4;
    localparam int CNT_W       = 3;

    typedef enum logic [2:0] {
        EV_CONTENT  = 3'd0,
        EV_STREND   = 3'd1,
        EV_MAPOPEN  = 3'd2,
        EV_MAPCLOSE = 3'd3,
        EV_ARROPEN  = 3'd4,
        EV_ARRCLOSE = 3'd5,
        EV_EOF      = 3'd6,
        EV_ERROR    = 3'd7
    } ev_kind_t;

    typedef enum logic [8:0] {
        MODE_IDLE      = 9'b000000001,
        MODE_SLASH     = 9'b000000010,
        MODE_LINE      = 9'b000000100,
        MODE_BLOCK     = 9'b000001000,
        MODE_BLOCKSTAR = 9'b000010000,
        MODE_QUOTED    = 9'b000100000,
        MODE_QUOTEDESC = 9'b001000000,
        MODE_UNQ       = 9'b010000000,
        MODE_UNQESC    = 9'b100000000
    } mode_t;

    typedef struct packed {
        ev_kind_t    kind;
        logic [7:0]  content;
        logic        last;
    } result_t;

    typedef struct packed {
        mode_t                           next_mode;
        logic [RES_IDX_W-1:0]            count;
        result_t [MAX_RESULTS-1:0]       res;
    } step_t;

endpackage

`default_nettype wire

// File: hw/rtl/ctt_byte_if.sv
// input channel: one text byte or end-of-input mark per transfer
`default_nettype none

interface ctt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink   (input valid, input data_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ctt_event_if.sv
// output channel: one lexer event per transfer
`default_nettype none

interface ctt_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_kind;
    logic [7:0] content_byte;
    logic       last_of_run;

    modport source (output valid, output event_kind, output content_byte,
                    output last_of_run, input ready);
    modport sink   (input valid, input event_kind, input content_byte,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ctt_lexer.sv
// combinational lexer step: mode and one byte in, next mode and up to three events out
`default_nettype none

module ctt_lexer
    import ctt_pkg::*;
(
    input  mode_t      mode,
    input  logic [7:0] data_byte,
    input  logic       end_of_input,
    output step_t      step
);

    logic                 is_space;
    logic                 is_graph;
    logic                 unq_keep;
    logic                 run_unq;
    logic                 run_idle;
    logic [RES_IDX_W-1:0] n;
    result_t [MAX_RESULTS-1:0] res;
    mode_t                nmode;

    assign is_space = (data_byte == CH_SPACE) || (data_byte >= CH_TAB && data_byte <= CH_CR);
    assign is_graph = (data_byte >= CH_GRAPH_LO) && (data_byte <= CH_GRAPH_HI);
    // bytes that continue an unquoted run
    assign unq_keep = is_graph && data_byte != CH_LBRACE && data_byte != CH_RBRACE &&
                      data_byte != CH_LBRACK && data_byte != CH_RBRACK &&
                      data_byte != CH_QUOTE;

    always_comb
    begin
        res      = '0;
        n        = '0;
        nmode    = mode;
        run_unq  = 1'b0;
        run_idle = 1'b0;

        if (end_of_input)
        begin
            case (mode)
                MODE_QUOTED, MODE_QUOTEDESC, MODE_UNQ, MODE_UNQESC:
                begin
                    res[n].kind = EV_STREND;
                    n = n + 2'd1;
                end
                MODE_SLASH:
                begin
                    res[n].kind    = EV_CONTENT;
                    res[n].content = CH_SLASH;
                    n = n + 2'd1;
                    res[n].kind = EV_STREND;
                    n = n + 2'd1;
                end
                default:
                begin
                end
            endcase
            res[n].kind = EV_EOF;
            n = n + 2'd1;
            nmode = MODE_IDLE;
        end
        else
        begin
            case (mode)
                MODE_SLASH:
                begin
                    if (data_byte == CH_SLASH)
                    begin
                        nmode = MODE_LINE;
                    end
                    else if (data_byte == CH_STAR)
                    begin
                        nmode = MODE_BLOCK;
                    end
                    else
                    begin
                        // lone slash opens an unquoted run
                        res[n].kind    = EV_CONTENT;
                        res[n].content = CH_SLASH;
                        n = n + 2'd1;
                        run_unq = 1'b1;
                    end
                end
                MODE_LINE:
                begin
                    if (data_byte == CH_LF || data_byte == CH_CR)
                    begin
                        nmode = MODE_IDLE;
                    end
                end
                MODE_BLOCK:
                begin
                    if (data_byte == CH_STAR)
                    begin
                        nmode = MODE_BLOCKSTAR;
                    end
                end
                MODE_BLOCKSTAR:
                begin
                    if (data_byte == CH_SLASH)
                    begin
                        nmode = MODE_IDLE;
                    end
                    else if (data_byte != CH_STAR)
                    begin
                        nmode = MODE_BLOCK;
                    end
                end
                MODE_QUOTED:
                begin
                    if (data_byte == CH_QUOTE)
                    begin
                        res[n].kind = EV_STREND;
                        n = n + 2'd1;
                        nmode = MODE_IDLE;
                    end
                    else if (data_byte == CH_BSLASH)
                    begin
                        nmode = MODE_QUOTEDESC;
                    end
                    else
                    begin
                        res[n].kind    = EV_CONTENT;
                        res[n].content = data_byte;
                        n = n + 2'd1;
                    end
                end
                MODE_QUOTEDESC:
                begin
                    res[n].kind    = EV_CONTENT;
                    res[n].content = data_byte;
                    n = n + 2'd1;
                    nmode = MODE_QUOTED;
                end
                MODE_UNQ:
                begin
                    run_unq = 1'b1;
                end
                MODE_UNQESC:
                begin
                    res[n].kind    = EV_CONTENT;
                    res[n].content = data_byte;
                    n = n + 2'd1;
                    nmode = MODE_UNQ;
                end
                default:
                begin
                    run_idle = 1'b1;
                end
            endcase

            if (run_unq)
            begin
                if (unq_keep)
                begin
                    if (data_byte == CH_BSLASH)
                    begin
                        nmode = MODE_UNQESC;
                    end
                    else
                    begin
                        res[n].kind    = EV_CONTENT;
                        res[n].content = data_byte;
                        n = n + 2'd1;
                        nmode = MODE_UNQ;
                    end
                end
                else
                begin
                    // run ends; the stopping byte is lexed again from idle
                    res[n].kind = EV_STREND;
                    n = n + 2'd1;
                    run_idle = 1'b1;
                end
            end

            if (run_idle)
            begin
                nmode = MODE_IDLE;
                if (!is_space)
                begin
                    case (data_byte)
                        CH_QUOTE:  nmode = MODE_QUOTED;
                        CH_SLASH:  nmode = MODE_SLASH;
                        CH_BSLASH: nmode = MODE_UNQESC;
                        CH_LBRACE:
                        begin
                            res[n].kind = EV_MAPOPEN;
                            n = n + 2'd1;
                        end
                        CH_RBRACE:
                        begin
                            res[n].kind = EV_MAPCLOSE;
                            n = n + 2'd1;
                        end
                        CH_LBRACK:
                        begin
                            res[n].kind = EV_ARROPEN;
                            n = n + 2'd1;
                        end
                        CH_RBRACK:
                        begin
                            res[n].kind = EV_ARRCLOSE;
                            n = n + 2'd1;
                        end
                        default:
                        begin
                            if (is_graph)
                            begin
                                res[n].kind    = EV_CONTENT;
                                res[n].content = data_byte;
                                n = n + 2'd1;
                                nmode = MODE_UNQ;
                            end
                            else
                            begin
                                res[n].kind = EV_ERROR;
                                n = n + 2'd1;
                            end
                        end
                    endcase
                end
            end
        end

        if (n != '0)
        begin
            res[n - 2'd1].last = 1'b1;
        end

        step.next_mode = nmode;
        step.count     = n;
        step.res       = res;
    end

endmodule

`default_nettype wire

// File: hw/rtl/config_text_tokenizer_unit.sv
// top level of the config text tokenizer: lexer step, mode register and event queue
// the events of an item are written into the registered event queue and offered from its head
// throughput: 1 item per cycle while each item gives at most one event and the sink keeps up;
//   an item giving 2 or 3 events is offered one event per transfer
// input ready while the 4-entry event queue holds at most one event
// reset (rst_n low, asynchronous): lexer back to idle between tokens, event queue empty
`default_nettype none

module config_text_tokenizer_unit
    import ctt_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    ctt_byte_if.sink     text,
    ctt_event_if.source  events
);

    // lexer mode, updated on every input transfer
    mode_t mode_reg;
    mode_t mode_next;

    // event queue: entry 0 is the head, entries shift down on each output transfer
    result_t [QUEUE_DEPTH-1:0] q_reg;
    result_t [QUEUE_DEPTH-1:0] q_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;

    step_t            step;
    logic             in_xfer;
    logic             out_xfer;
    logic [CNT_W-1:0] cnt_after_pop;
    logic [CNT_W-1:0] push_n;

    ctt_lexer u_lexer (
        .mode         (mode_reg),
        .data_byte    (text.data_byte),
        .end_of_input (text.end_of_input),
        .step         (step)
    );

    // room for a full burst of events, judged on registered state only
    assign text.ready = (count_reg <= CNT_W'(QUEUE_DEPTH - MAX_RESULTS));
    assign in_xfer    = text.valid && text.ready;

    assign events.valid        = (count_reg != '0);
    assign events.event_kind   = q_reg[0].kind;
    assign events.content_byte = q_reg[0].content;
    assign events.last_of_run  = q_reg[0].last;
    assign out_xfer            = events.valid && events.ready;

    assign mode_next     = in_xfer ? step.next_mode : mode_reg;
    assign cnt_after_pop = count_reg - CNT_W'(out_xfer);
    assign push_n        = in_xfer ? CNT_W'(step.count) : '0;
    assign count_next    = cnt_after_pop + push_n;

    // each entry takes either its shifted neighbor or one of the new events
    always_comb
    begin
        result_t          shifted;
        logic [CNT_W-1:0] rel;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (out_xfer && (i + 1 < QUEUE_DEPTH))
            begin
                shifted = q_reg[(i + 1) % QUEUE_DEPTH];
            end
            else
            begin
                shifted = q_reg[i];
            end
            rel = CNT_W'(i) - cnt_after_pop;
            if (CNT_W'(i) >= cnt_after_pop && rel < push_n)
            begin
                q_next[i] = step.res[rel[RES_IDX_W-1:0]];
            end
            else
            begin
                q_next[i] = shifted;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            count_reg <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    // queue payload needs no reset
    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

endmodule

`default_nettype wire

// File: hw/rtl/ctt_checker.sv
// port-level assertions for the config text tokenizer, bound to the top level
`default_nettype none

module ctt_checker
    import ctt_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       text_valid,
    input wire logic       text_ready,
    input wire logic       text_eoi,
    input wire logic       ev_valid,
    input wire logic       ev_ready,
    input wire logic [2:0] ev_kind,
    input wire logic [7:0] ev_content,
    input wire logic       ev_last
);

    // a stalled event holds
    a_ev_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && !ev_ready |=> ev_valid && $stable(ev_kind) && $stable(ev_content)
            && $stable(ev_last))
        else $error("stalled event changed");

    // every end-of-input transfer leaves at least one event to offer
    a_eoi_event: assert property (@(posedge clk) disable iff (!rst_n)
        text_valid && text_ready && text_eoi |=> ev_valid)
        else $error("end of input gave no event");

    // end of file is always the last event of its run
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && ev_kind == EV_EOF |-> ev_last)
        else $error("end of file not last of run");

    // only content events carry a byte
    a_content_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid && ev_kind != EV_CONTENT |-> ev_content == 8'h00)
        else $error("non-content event carries a byte");

endmodule

bind config_text_tokenizer_unit ctt_checker u_ctt_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .text_valid (text.valid),
    .text_ready (text.ready),
    .text_eoi   (text.end_of_input),
    .ev_valid   (events.valid),
    .ev_ready   (events.ready),
    .ev_kind    (events.event_kind),
    .ev_content (events.content_byte),
    .ev_last    (events.last_of_run)
);

`default_nettype wire
